// ===== rtl/core/deq_pkg.sv =====
// shared types, constants and helpers for the double-ended queue
package deq_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = 5;
    localparam int POS_W       = 5;
    localparam int WORD_W      = 32;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_AW     = $clog2(CMDQ_DEPTH);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_AW     = $clog2(RESQ_DEPTH);

    typedef enum logic [2:0] {
        OP_ADD_BACK   = 3'd0,
        OP_ADD_FRONT  = 3'd1,
        OP_TAKE_BACK  = 3'd2,
        OP_TAKE_FRONT = 3'd3,
        OP_READ       = 3'd4,
        OP_INSERT     = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NOP        = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHIFT
    } t_back_state;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } t_out_item;

    typedef struct packed {
        t_op                      op;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic take;
    } t_cmd_hs;

    // ring slot of a logical position, depth is a power of two
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] front,
        input logic [CNT_W-1:0] pos
    );
        return front + pos[IDX_W-1:0];
    endfunction

    function automatic t_out_item make_res(
        input logic signed [WORD_W-1:0] data,
        input t_status                  status,
        input logic [CNT_W-1:0]         count
    );
        t_out_item r;
        r.data     = data;
        r.status   = status;
        r.count    = count;
        r.is_empty = (count == '0);
        return r;
    endfunction

endpackage

// ===== rtl/core/deq_front.sv =====
// front end: accepts input transactions, decodes the op and queues commands
module deq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  deq_pkg::t_in_item  i_item,
    output logic               o_full,
    output deq_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_take
);

    deq_pkg::t_cmd                r_q [deq_pkg::CMDQ_DEPTH];
    logic [deq_pkg::CMDQ_AW-1:0]  r_wp;
    logic [deq_pkg::CMDQ_AW-1:0]  r_rp;
    logic [deq_pkg::CMDQ_AW:0]    r_cnt;
    logic                         push_ok;
    logic                         take_ok;
    deq_pkg::t_cmd                dec;

    assign o_full      = (r_cnt == (deq_pkg::CMDQ_AW+1)'(deq_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push_ok     = i_push && !o_full;
    assign take_ok     = i_cmd_take && o_cmd_valid;

    always_comb begin
        dec.op       = deq_pkg::t_op'(i_item.op);
        dec.value    = i_item.value;
        dec.position = i_item.position;
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (take_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_ok, take_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/deq_back.sv =====
// back end: ring store, pointer state, insert shifter and result queue
module deq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_cmd      i_cmd,
    input  deq_pkg::t_cmd_hs   i_hs_in,
    output deq_pkg::t_cmd_hs   o_hs_out,
    output logic               o_empty,
    input  logic               i_pop,
    output deq_pkg::t_out_item o_res
);

    deq_pkg::t_back_state               r_state, n_state;
    logic [deq_pkg::CNT_W-1:0]          r_count, n_count;
    logic [deq_pkg::IDX_W-1:0]          r_front, n_front;
    logic [deq_pkg::CNT_W-1:0]          r_i, n_i;
    logic [deq_pkg::POS_W-1:0]          r_pos, n_pos;
    logic signed [deq_pkg::WORD_W-1:0]  r_value, n_value;
    logic                               r_wv, n_wv;
    logic [deq_pkg::IDX_W-1:0]          r_wa, n_wa;
    logic signed [deq_pkg::WORD_W-1:0]  r_mem [deq_pkg::DEPTH];
    logic signed [deq_pkg::WORD_W-1:0]  r_rdata;

    deq_pkg::t_out_item                 r_rq [deq_pkg::RESQ_DEPTH];
    logic [deq_pkg::RESQ_AW-1:0]        r_rwp;
    logic [deq_pkg::RESQ_AW-1:0]        r_rrp;
    logic [deq_pkg::RESQ_AW:0]          r_rcnt;

    logic                               we;
    logic [deq_pkg::IDX_W-1:0]          wa;
    logic signed [deq_pkg::WORD_W-1:0]  wd;
    logic [deq_pkg::IDX_W-1:0]          ra;
    logic                               res_push;
    logic                               res_pop;
    deq_pkg::t_out_item                 res_item;
    logic                               res_space;
    logic                               start;
    logic                               is_full;
    logic                               is_emp;
    logic                               shift_more;
    logic                               shift_done;

    assign res_space  = (r_rcnt != (deq_pkg::RESQ_AW+1)'(deq_pkg::RESQ_DEPTH));
    assign start      = (r_state == deq_pkg::BK_IDLE) && i_hs_in.valid && res_space;
    assign is_full    = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign is_emp     = (r_count == '0);
    assign shift_more = (r_i > r_pos);
    assign shift_done = !shift_more && !r_wv;
    assign res_pop    = i_pop && !o_empty;
    assign o_empty    = (r_rcnt == '0);
    assign o_res      = r_rq[r_rrp];

    always_comb begin
        o_hs_out.valid = 1'b0;
        o_hs_out.take  = start;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::BK_IDLE: begin
                if (start) begin
                    case (i_cmd.op)
                        deq_pkg::OP_TAKE_BACK, deq_pkg::OP_TAKE_FRONT: begin
                            if (!is_emp) begin
                                n_state = deq_pkg::BK_READ;
                            end
                        end
                        deq_pkg::OP_READ: begin
                            if (i_cmd.position < r_count) begin
                                n_state = deq_pkg::BK_READ;
                            end
                        end
                        deq_pkg::OP_INSERT: begin
                            if (i_cmd.position <= r_count && !is_full) begin
                                n_state = deq_pkg::BK_SHIFT;
                            end
                        end
                        default: n_state = deq_pkg::BK_IDLE;
                    endcase
                end
            end
            deq_pkg::BK_READ:  n_state = deq_pkg::BK_IDLE;
            deq_pkg::BK_SHIFT: begin
                if (shift_done) begin
                    n_state = deq_pkg::BK_IDLE;
                end
            end
            default: n_state = deq_pkg::BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_front  = r_front;
        n_i      = r_i;
        n_pos    = r_pos;
        n_value  = r_value;
        n_wv     = 1'b0;
        n_wa     = r_wa;
        we       = 1'b0;
        wa       = '0;
        wd       = '0;
        ra       = r_front;
        res_push = 1'b0;
        res_item = deq_pkg::make_res('0, deq_pkg::ST_OK, r_count);
        case (r_state)
            deq_pkg::BK_IDLE: begin
                if (start) begin
                    case (i_cmd.op)
                        deq_pkg::OP_ADD_BACK: begin
                            res_push = 1'b1;
                            if (is_full) begin
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_FULL, r_count);
                            end else begin
                                we       = 1'b1;
                                wa       = deq_pkg::slot_of(r_front, r_count);
                                wd       = i_cmd.value;
                                n_count  = r_count + 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_OK, n_count);
                            end
                        end
                        deq_pkg::OP_ADD_FRONT: begin
                            res_push = 1'b1;
                            if (is_full) begin
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_FULL, r_count);
                            end else begin
                                n_front  = r_front - 1'b1;
                                we       = 1'b1;
                                wa       = n_front;
                                wd       = i_cmd.value;
                                n_count  = r_count + 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_OK, n_count);
                            end
                        end
                        deq_pkg::OP_TAKE_BACK: begin
                            if (is_emp) begin
                                res_push = 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_EMPTY, r_count);
                            end else begin
                                n_count = r_count - 1'b1;
                                ra      = deq_pkg::slot_of(r_front, n_count);
                            end
                        end
                        deq_pkg::OP_TAKE_FRONT: begin
                            if (is_emp) begin
                                res_push = 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_EMPTY, r_count);
                            end else begin
                                ra      = r_front;
                                n_front = r_front + 1'b1;
                                n_count = r_count - 1'b1;
                            end
                        end
                        deq_pkg::OP_READ: begin
                            if (i_cmd.position >= r_count) begin
                                res_push = 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_BAD_INDEX,
                                                             r_count);
                            end else begin
                                ra = deq_pkg::slot_of(r_front, i_cmd.position);
                            end
                        end
                        deq_pkg::OP_INSERT: begin
                            if (i_cmd.position > r_count) begin
                                res_push = 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_BAD_INDEX,
                                                             r_count);
                            end else if (is_full) begin
                                res_push = 1'b1;
                                res_item = deq_pkg::make_res('0, deq_pkg::ST_FULL, r_count);
                            end else begin
                                n_i     = r_count;
                                n_pos   = i_cmd.position;
                                n_value = i_cmd.value;
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            n_count  = '0;
                            n_front  = '0;
                            res_push = 1'b1;
                            res_item = deq_pkg::make_res('0, deq_pkg::ST_OK, '0);
                        end
                        default: begin
                            res_push = 1'b1;
                            res_item = deq_pkg::make_res('0, deq_pkg::ST_OK, r_count);
                        end
                    endcase
                end
            end
            deq_pkg::BK_READ: begin
                res_push = 1'b1;
                res_item = deq_pkg::make_res(r_rdata, deq_pkg::ST_OK, r_count);
            end
            deq_pkg::BK_SHIFT: begin
                if (r_wv) begin
                    we = 1'b1;
                    wa = r_wa;
                    wd = r_rdata;
                end
                if (shift_more) begin
                    ra   = deq_pkg::slot_of(r_front, r_i - 1'b1);
                    n_wv = 1'b1;
                    n_wa = deq_pkg::slot_of(r_front, r_i);
                    n_i  = r_i - 1'b1;
                end else if (!r_wv) begin
                    we       = 1'b1;
                    wa       = deq_pkg::slot_of(r_front, r_pos);
                    wd       = r_value;
                    n_count  = r_count + 1'b1;
                    res_push = 1'b1;
                    res_item = deq_pkg::make_res('0, deq_pkg::ST_OK, n_count);
                end
            end
            default: begin
                res_push = 1'b0;
            end
        endcase
    end

    // ring store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rdata <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_value <= n_value;
        r_wa    <= n_wa;
        r_i     <= n_i;
        if (res_push) begin
            r_rq[r_rwp] <= res_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::BK_IDLE;
            r_count <= '0;
            r_front <= '0;
            r_wv    <= 1'b0;
            r_rwp   <= '0;
            r_rrp   <= '0;
            r_rcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_front <= n_front;
            r_wv    <= n_wv;
            if (res_push) begin
                r_rwp <= r_rwp + 1'b1;
            end
            if (res_pop) begin
                r_rrp <= r_rrp + 1'b1;
            end
            case ({res_push, res_pop})
                2'b10:   r_rcnt <= r_rcnt + 1'b1;
                2'b01:   r_rcnt <= r_rcnt - 1'b1;
                default: r_rcnt <= r_rcnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
// top level of the double-ended queue
//
//   channel   handshake        payload
//   input     i_push / o_full  i_item (op, value, position)
//   result    o_empty / i_pop  o_res  (data, status, count, is_empty)
//
// pop front/back and read pass through BK_READ in the back end, since the store
// read is registered; push, clear, nop and failed ops finish in BK_IDLE; insert at
// position p shifts entries up one per cycle in BK_SHIFT, then writes the value.
// reset is synchronous and empties the deque; the store itself is not cleared
// a two-deep command queue and a two-deep result queue let each side stall alone
module double_ended_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  deq_pkg::t_in_item  i_item,
    output logic               o_full,
    output logic               o_empty,
    input  logic               i_pop,
    output deq_pkg::t_out_item o_res
);

    deq_pkg::t_cmd    cmd;
    deq_pkg::t_cmd_hs hs_to_back;
    deq_pkg::t_cmd_hs hs_from_back;
    logic             cmd_valid;

    always_comb begin
        hs_to_back.valid = cmd_valid;
        hs_to_back.take  = 1'b0;
    end

    deq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .o_full      (o_full),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (hs_from_back.take)
    );

    deq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_hs_in  (hs_to_back),
        .o_hs_out (hs_from_back),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_res    (o_res)
    );

endmodule
